>>> rtl/assert_macros.svh
// Assertion macros for the top-level RTL file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, checks masked while reset is low.
`define CHK_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`endif

>>> rtl/i2cbrd_pkg.sv
// Package for the I2C bit rate divider search core.
// Holds default parameters and field widths; no dependencies.
package i2cbrd_pkg;

    localparam int unsigned CPU_HZ_DEF    = 16000000;
    localparam int unsigned PRESC_DEF     = 4;
    localparam int unsigned RATE_IN_W     = 22;
    localparam int unsigned DIV_W         = 8;
    localparam int unsigned CODE_W        = 2;
    localparam int unsigned ACH_W         = 20;
    localparam logic [DIV_W-1:0] DIV_MAX  = 8'hFF;
    localparam logic [ACH_W-1:0] RATE_MAX = 20'hFFFFF;

    // Lane pipeline depth for a given rate width.
    function automatic int unsigned lane_lat(input int unsigned rw);
        return 11 + rw;
    endfunction

endpackage

>>> rtl/i2cbrd_lane.sv
// One prescaler lane: divider by restoring division, then achieved rate and error.
// Depends on i2cbrd_pkg.
module i2cbrd_lane
    import i2cbrd_pkg::*;
#(
    parameter int unsigned CPU_HZ = CPU_HZ_DEF,
    parameter int unsigned CODE   = 0
) (
    input  logic                              aclk,
    input  logic                              en,
    input  logic [$clog2(CPU_HZ+1)-5:0]       rate_i,
    output logic [DIV_W-1:0]                  div_o,
    output logic [$clog2(CPU_HZ+1)-5:0]       br_o,
    output logic [$clog2(CPU_HZ+1)-5:0]       err_o
);

    localparam int unsigned HW = $clog2(CPU_HZ + 1);
    localparam int unsigned RW = HW - 4;
    localparam int unsigned XW = HW + 12;
    localparam int unsigned YW = HW + 17;
    localparam int unsigned SH = 2 * CODE + 1;
    localparam int unsigned NQ = RW;
    localparam int unsigned EB = 10 + NQ;
    localparam logic [XW-1:0] HZ_X = XW'(CPU_HZ);
    localparam logic [YW-1:0] HZ_Y = YW'(CPU_HZ);

    logic [XW-1:0]    num_reg [0:9];
    logic [XW-1:0]    den_reg [0:9];
    logic             ovf_reg [1:9];
    logic [DIV_W-1:0] q_reg   [1:9];
    logic [RW-1:0]    rt_reg  [0:EB-1];
    logic [DIV_W-1:0] dv_reg  [10:EB-1];
    logic [YW-1:0]    bd_reg  [10:EB-1];
    logic [YW-1:0]    rm_reg  [10:EB-1];
    logic [RW-1:0]    bq_reg  [10:EB-1];
    logic [DIV_W-1:0] div_reg;
    logic [RW-1:0]    br_reg;
    logic [RW-1:0]    err_reg;

    // stage 0: numerator with half-divisor rounding term, divisor
    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg[0] <= HZ_X - (XW'(rate_i) << 4) + (XW'(rate_i) << (2 * CODE));
            den_reg[0] <= XW'(rate_i) << SH;
            rt_reg[0]  <= rate_i;
        end
    end

    // stage 1: quotient of 256 or more clamps
    always_ff @(posedge aclk) begin
        if (en) begin
            ovf_reg[1] <= num_reg[0] >= (den_reg[0] << 8);
            num_reg[1] <= num_reg[0];
            den_reg[1] <= den_reg[0];
            q_reg[1]   <= '0;
            rt_reg[1]  <= rt_reg[0];
        end
    end

    // stages 2..9: one quotient bit each, msb first
    for (genvar s = 2; s <= 9; s++) begin : g_dq
        localparam int unsigned K = 9 - s;
        logic tst;
        logic [DIV_W-1:0] q_c;
        assign tst = num_reg[s-1] >= (den_reg[s-1] << K);
        always_comb begin
            q_c    = q_reg[s-1];
            q_c[K] = tst;
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                num_reg[s] <= tst ? num_reg[s-1] - (den_reg[s-1] << K) : num_reg[s-1];
                den_reg[s] <= den_reg[s-1];
                ovf_reg[s] <= ovf_reg[s-1];
                q_reg[s]   <= q_c;
                rt_reg[s]  <= rt_reg[s-1];
            end
        end
    end

    // stage 10: clamp divider, build bus period denominator
    logic [DIV_W-1:0] dv_c;
    assign dv_c = ovf_reg[9] ? DIV_MAX : q_reg[9];

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_reg[10] <= dv_c;
            bd_reg[10] <= YW'(16) + (YW'(dv_c) << SH);
            rm_reg[10] <= HZ_Y;
            bq_reg[10] <= '0;
            rt_reg[10] <= rt_reg[9];
        end
    end

    // stages 11..10+NQ: achieved rate, one bit each
    for (genvar j = 1; j <= NQ; j++) begin : g_rq
        localparam int unsigned S = 10 + j;
        localparam int unsigned K = NQ - j;
        logic tst;
        assign tst = rm_reg[S-1] >= (bd_reg[S-1] << K);
        if (S < EB) begin : g_mid
            logic [RW-1:0] bq_c;
            always_comb begin
                bq_c    = bq_reg[S-1];
                bq_c[K] = tst;
            end
            always_ff @(posedge aclk) begin
                if (en) begin
                    rm_reg[S] <= tst ? rm_reg[S-1] - (bd_reg[S-1] << K) : rm_reg[S-1];
                    bd_reg[S] <= bd_reg[S-1];
                    bq_reg[S] <= bq_c;
                    dv_reg[S] <= dv_reg[S-1];
                    rt_reg[S] <= rt_reg[S-1];
                end
            end
        end else begin : g_last
            // last bit folds into the error stage
            logic [RW-1:0] br_c;
            always_comb begin
                br_c    = bq_reg[S-1];
                br_c[K] = tst;
            end
            always_ff @(posedge aclk) begin
                if (en) begin
                    br_reg  <= br_c;
                    div_reg <= dv_reg[S-1];
                    err_reg <= (br_c >= rt_reg[S-1]) ? br_c - rt_reg[S-1]
                                                     : rt_reg[S-1] - br_c;
                end
            end
        end
    end

    assign div_o = div_reg;
    assign br_o  = br_reg;
    assign err_o = err_reg;

endmodule

>>> rtl/i2c_bit_rate_divider_search_core.sv
// Top level of the I2C bit rate divider and prescaler search.
// Depends on i2cbrd_pkg, i2cbrd_lane and assert_macros.svh.
//
// Takes a requested I2C bit rate (Hz) per input word and returns the 8-bit
// divider, 2-bit prescaler code and achieved rate (Hz) for a part clocked at
// CPU_HZ. Rate is clamped to CPU_HZ/16 (zero counts as 1 Hz). One lane per
// prescaler code runs in parallel: a 9-stage restoring division gives the
// rounded, clamped divider, then a bit-serial pipelined division by the bus
// period gives the achieved rate, then its error. The first code with the
// smallest error wins. Throughput is one word per clock while not stalled; the
// path from input accept to m_tvalid is the input register, 11 + rate-width
// lane stages and the output register, the rate-width part coming from the
// one-bit-per-stage rate divider. The whole pipeline stalls together when
// m_tvalid is high and m_tready low, so s_tready follows m_tready through one gate.
module i2c_bit_rate_divider_search_core
    import i2cbrd_pkg::*;
#(
    parameter int unsigned CPU_HZ          = CPU_HZ_DEF,
    parameter int unsigned PRESCALER_STEPS = PRESC_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [21:0] requested_rate
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [7:0] divider, [9:8] prescaler_code,
                                   // [29:10] achieved_rate
);

`include "assert_macros.svh"

    localparam int unsigned HW  = $clog2(CPU_HZ + 1);
    localparam int unsigned RW  = HW - 4;
    localparam int unsigned CW  = ((HW > RATE_IN_W) ? HW : RATE_IN_W) + 1;
    localparam int unsigned AW  = RW + ACH_W;
    localparam int unsigned LAT = lane_lat(RW);
    localparam logic [CW-1:0] RMAX = CW'(CPU_HZ / 16);

    logic             adv;
    logic             vld_reg [0:LAT+1];
    logic [RW-1:0]    rate_reg;
    logic [31:0]      out_reg;

    logic [DIV_W-1:0] l_div [0:PRESCALER_STEPS-1];
    logic [RW-1:0]    l_br  [0:PRESCALER_STEPS-1];
    logic [RW-1:0]    l_err [0:PRESCALER_STEPS-1];

    // global stall: everything moves when the output slot frees up
    assign adv      = !vld_reg[LAT+1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[LAT+1];
    assign m_tdata  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= LAT + 1; i++) vld_reg[i] <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i <= LAT + 1; i++) vld_reg[i] <= vld_reg[i-1];
        end
    end

    // input stage: saturate to CPU_HZ/16, zero -> 1
    logic [CW-1:0] rq;
    logic [CW-1:0] rc;
    always_comb begin
        rq = CW'(s_tdata[RATE_IN_W-1:0]);
        if (rq == '0) rq = CW'(1);
        rc = (rq > RMAX) ? RMAX : rq;
        if (rc == '0) rc = CW'(1);
    end

    always_ff @(posedge aclk) begin
        if (adv) rate_reg <= rc[RW-1:0];
    end

    for (genvar c = 0; c < PRESCALER_STEPS; c++) begin : g_lane
        i2cbrd_lane #(
            .CPU_HZ (CPU_HZ),
            .CODE   (c)
        ) u_lane (
            .aclk   (aclk),
            .en     (adv),
            .rate_i (rate_reg),
            .div_o  (l_div[c]),
            .br_o   (l_br[c]),
            .err_o  (l_err[c])
        );
    end

    // pick first lane with smallest error; strict compare keeps lower code
    logic [DIV_W-1:0]  b_div;
    logic [CODE_W-1:0] b_code;
    logic [RW-1:0]     b_br;
    logic [RW-1:0]     b_err;
    logic [AW-1:0]     b_ach;
    logic [ACH_W-1:0]  ach;
    always_comb begin
        b_div  = l_div[0];
        b_code = '0;
        b_br   = l_br[0];
        b_err  = l_err[0];
        for (int c = 1; c < PRESCALER_STEPS; c++) begin
            if (l_err[c] < b_err) begin
                b_div  = l_div[c];
                b_code = CODE_W'(c);
                b_br   = l_br[c];
                b_err  = l_err[c];
            end
        end
        b_ach = AW'(b_br);
        ach   = (b_ach > AW'(RATE_MAX)) ? RATE_MAX : b_ach[ACH_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (adv) out_reg <= {2'b00, ach, b_code, b_div};
    end

    `CHK_ASSERT(a_acc_enters, aclk, aresetn, (s_tvalid && s_tready) |=> vld_reg[0],
        "accepted word not captured")
    `CHK_ASSERT(a_code_range, aclk, aresetn,
        m_tvalid |-> (32'(m_tdata[9:8]) < PRESCALER_STEPS), "prescaler code out of range")
    `CHK_ASSERT(a_rate_nz, aclk, aresetn, m_tvalid |-> (m_tdata[29:10] != 20'd0),
        "achieved rate is zero")

endmodule
